// ===== hw/rtl/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared types and codes of the sorted timer queue
// Command kinds, result status codes and the layout of one stored timer.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int TIME_W   = 32;
	localparam int ID_W     = 16;
	localparam int HELD_W   = 7;
	localparam int STATUS_W = 3;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_ADJUST = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE      = 3'd0,
		STATUS_EXPIRED   = 3'd1,
		STATUS_FULL      = 3'd2,
		STATUS_NOT_FOUND = 3'd3,
		STATUS_NONE      = 3'd4
	} status_t;

	// One timer as it sits in the table.
	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0]   owner;
	} entry_t;

endpackage

// ===== hw/rtl/sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue: table of timers kept in ascending order of expiry
// Add, adjust, delete and tick commands over a RAM-backed sorted list that a
// small sequencer walks one entry per cycle.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                   Transfer
// command   start, busy, kind, conn_id,               start high and busy low
//           expire_time, now                          at a rising edge
// result    result_valid, status, expired_id,         every cycle with
//           expired_at, held, last                    result_valid high
//
// The time a command takes grows with the number of timers held, since the
// single read port of the table RAM is walked one entry per cycle.
// Reset clears the count of held timers; the table contents are not cleared
// and need no clearing pass, since only entries below the count are used.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_timer_queue
	import stq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [ID_W-1:0]     conn_id,
	input  logic [TIME_W-1:0]   expire_time,
	input  logic [TIME_W-1:0]   now,
	output logic                result_valid,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     expired_id,
	output logic [TIME_W-1:0]   expired_at,
	output logic [HELD_W-1:0]   held,
	output logic                last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// Sequencer states. INS walks downward moving later entries up by one
	// until the slot for the new timer is found. DEL walks upward looking for
	// the owner and closes the gap behind it. TICK walks upward reporting
	// expired timers one step late (so the final one can be marked) and then
	// moves the survivors down to the head of the table.
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_PREP,
		S_INS,
		S_PUT0,
		S_DEL,
		S_TICK,
		S_FLUSH
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     dix_q;
	kind_t             kind_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] time_q;
	logic              found_q;
	logic              shift_q;
	logic [CW-1:0]     k_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [TIME_W-1:0] pend_at_q;

	logic                rvalid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     eid_q;
	logic [TIME_W-1:0]   eat_q;
	logic [HELD_W-1:0]   held_q;
	logic                last_q;

	// RAM port signals.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;

	entry_t        rd;
	entry_t        new_entry;
	logic [AW-1:0] last_idx;
	logic          ins_move;
	logic          del_hit;
	logic          tick_exp;
	logic          found_now;
	kind_t         kind_in;

	stq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd        = entry_t'(ram_rdata);
	assign new_entry = '{expiry: time_q, owner: id_q};
	assign kind_in   = kind_t'(kind);

	// Index of the highest held entry; only meaningful when the count is
	// nonzero, which every state that uses it guarantees.
	assign last_idx  = AW'(cnt_q - CW'(1));

	// An entry later than the new expiry moves up; equal expiries stay ahead.
	assign ins_move  = rd.expiry > time_q;
	assign del_hit   = rd.owner == id_q;
	assign tick_exp  = rd.expiry <= time_q;
	assign found_now = found_q | del_hit;

	// Table port control. Reads run one entry ahead of the entry being
	// evaluated; a read past either end of the list is simply ignored.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = dix_q;
		ram_wdata = rd;
		ram_raddr = dix_q;
		unique case (state_q)
			S_IDLE: begin
				ram_raddr = (kind_in == KIND_ADD) ? last_idx : '0;
			end
			S_INS_PREP: begin
				ram_raddr = last_idx;
			end
			S_INS: begin
				ram_raddr = dix_q - AW'(1);
				ram_we    = 1'b1;
				ram_waddr = dix_q + AW'(1);
				ram_wdata = ins_move ? rd : new_entry;
			end
			S_PUT0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = new_entry;
			end
			S_DEL: begin
				ram_raddr = dix_q + AW'(1);
				ram_we    = found_q;
				ram_waddr = dix_q - AW'(1);
			end
			S_TICK: begin
				ram_raddr = dix_q + AW'(1);
				ram_we    = (k_q != '0) && (shift_q || !tick_exp);
				ram_waddr = AW'(dix_q - k_q);
			end
			S_FLUSH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			dix_q     <= '0;
			kind_q    <= KIND_ADD;
			id_q      <= '0;
			time_q    <= '0;
			found_q   <= 1'b0;
			shift_q   <= 1'b0;
			k_q       <= '0;
			pend_id_q <= '0;
			pend_at_q <= '0;
			rvalid_q  <= 1'b0;
			status_q  <= STATUS_DONE;
			eid_q     <= '0;
			eat_q     <= '0;
			held_q    <= '0;
			last_q    <= 1'b0;
		end else begin
			rvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q  <= kind_in;
						id_q    <= conn_id;
						time_q  <= (kind_in == KIND_TICK) ? now : expire_time;
						found_q <= 1'b0;
						shift_q <= 1'b0;
						k_q     <= '0;
						eid_q   <= '0;
						eat_q   <= '0;
						last_q  <= 1'b1;
						unique case (kind_in)
							KIND_ADD: begin
								if (cnt_q == CW'(CAPACITY)) begin
									rvalid_q <= 1'b1;
									status_q <= STATUS_FULL;
									held_q   <= HELD_W'(cnt_q);
								end else if (cnt_q == '0) begin
									state_q <= S_PUT0;
								end else begin
									dix_q   <= last_idx;
									state_q <= S_INS;
								end
							end
							KIND_ADJUST, KIND_DELETE: begin
								if (cnt_q == '0) begin
									rvalid_q <= 1'b1;
									status_q <= STATUS_NOT_FOUND;
									held_q   <= '0;
								end else begin
									dix_q   <= '0;
									state_q <= S_DEL;
								end
							end
							KIND_TICK: begin
								if (cnt_q == '0) begin
									rvalid_q <= 1'b1;
									status_q <= STATUS_NONE;
									held_q   <= '0;
								end else begin
									dix_q   <= '0;
									state_q <= S_TICK;
								end
							end
							default: begin
							end
						endcase
					end
				end

				S_INS_PREP: begin
					dix_q   <= last_idx;
					state_q <= S_INS;
				end

				S_INS: begin
					dix_q <= dix_q - AW'(1);
					if (ins_move) begin
						// The bottom entry moved up too: the new timer goes first.
						if (dix_q == '0) begin
							state_q <= S_PUT0;
						end
					end else begin
						rvalid_q <= 1'b1;
						status_q <= STATUS_DONE;
						eid_q    <= '0;
						eat_q    <= '0;
						last_q   <= 1'b1;
						held_q   <= HELD_W'(cnt_q + CW'(1));
						cnt_q    <= cnt_q + CW'(1);
						state_q  <= S_IDLE;
					end
				end

				S_PUT0: begin
					rvalid_q <= 1'b1;
					status_q <= STATUS_DONE;
					eid_q    <= '0;
					eat_q    <= '0;
					last_q   <= 1'b1;
					held_q   <= HELD_W'(cnt_q + CW'(1));
					cnt_q    <= cnt_q + CW'(1);
					state_q  <= S_IDLE;
				end

				S_DEL: begin
					dix_q   <= dix_q + AW'(1);
					found_q <= found_now;
					if (dix_q == last_idx) begin
						if (!found_now) begin
							rvalid_q <= 1'b1;
							status_q <= STATUS_NOT_FOUND;
							held_q   <= HELD_W'(cnt_q);
							state_q  <= S_IDLE;
						end else begin
							cnt_q <= cnt_q - CW'(1);
							if (kind_q == KIND_DELETE) begin
								rvalid_q <= 1'b1;
								status_q <= STATUS_DONE;
								held_q   <= HELD_W'(cnt_q - CW'(1));
								state_q  <= S_IDLE;
							end else if (cnt_q == CW'(1)) begin
								// Adjust of the only timer: the table is now empty.
								state_q <= S_PUT0;
							end else begin
								state_q <= S_INS_PREP;
							end
						end
					end
				end

				S_TICK: begin
					dix_q <= dix_q + AW'(1);
					if (shift_q) begin
						if (dix_q == last_idx) begin
							cnt_q   <= cnt_q - k_q;
							state_q <= S_IDLE;
						end
					end else if (tick_exp) begin
						// Report the previous expired timer, now known not final.
						if (k_q != '0) begin
							rvalid_q <= 1'b1;
							status_q <= STATUS_EXPIRED;
							eid_q    <= pend_id_q;
							eat_q    <= pend_at_q;
							held_q   <= HELD_W'(cnt_q - k_q);
							last_q   <= 1'b0;
						end
						pend_id_q <= rd.owner;
						pend_at_q <= rd.expiry;
						k_q       <= k_q + CW'(1);
						if (dix_q == last_idx) begin
							state_q <= S_FLUSH;
						end
					end else if (k_q == '0) begin
						rvalid_q <= 1'b1;
						status_q <= STATUS_NONE;
						held_q   <= HELD_W'(cnt_q);
						state_q  <= S_IDLE;
					end else begin
						// First survivor: the held report is the final one.
						rvalid_q <= 1'b1;
						status_q <= STATUS_EXPIRED;
						eid_q    <= pend_id_q;
						eat_q    <= pend_at_q;
						held_q   <= HELD_W'(cnt_q - k_q);
						last_q   <= 1'b1;
						shift_q  <= 1'b1;
						if (dix_q == last_idx) begin
							cnt_q   <= cnt_q - k_q;
							state_q <= S_IDLE;
						end
					end
				end

				S_FLUSH: begin
					rvalid_q <= 1'b1;
					status_q <= STATUS_EXPIRED;
					eid_q    <= pend_id_q;
					eat_q    <= pend_at_q;
					held_q   <= HELD_W'(cnt_q - k_q);
					last_q   <= 1'b1;
					cnt_q    <= cnt_q - k_q;
					state_q  <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = rvalid_q;
	assign status       = status_q;
	assign expired_id   = eid_q;
	assign expired_at   = eat_q;
	assign held         = held_q;
	assign last         = last_q;

endmodule

// ===== hw/rtl/stq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ram: generic simple dual-port RAM
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module stq_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
